>>> design/igt_pkg.sv
// igt_pkg: shared constants, types and state codes for the iterative global threshold unit
// no dependencies
package igt_pkg;
    localparam int BINS        = 256;
    localparam int BIN_BITS    = 8;
    localparam int COUNT_BITS  = 22;
    localparam int MAX_PASSES  = 32;
    localparam int PASS_BITS   = 8;
    localparam int SUM_BITS    = COUNT_BITS + 2 * BIN_BITS;
    localparam int CNT_BITS    = COUNT_BITS + BIN_BITS;
    localparam logic [COUNT_BITS-1:0] BIN_MAX = {COUNT_BITS{1'b1}};

    localparam logic [7:0] CFG_INITIAL_THRESHOLD = 8'd0;
    localparam logic [7:0] CFG_TOLERANCE_HALVES  = 8'd1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_INC_RD, ST_INC_WR, ST_SCAN, ST_SCAN_LAST, ST_DIV_LO, ST_DIV_HI,
        ST_CHECK, ST_CLEAR, ST_OUT
    } t_state;

    typedef struct packed {
        logic                start;
        logic [SUM_BITS-1:0] num;
        logic [CNT_BITS-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic         done;
        logic [8:0]   quot;
    } t_div_rsp;
endpackage

>>> design/igt_ram.sv
// igt_ram: generic single-port ram with registered read
// no dependencies
module igt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

>>> design/igt_div.sv
// igt_div: restoring divider, one quotient bit per cycle, 9-bit quotient
// depends on igt_pkg
module igt_div import igt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [SUM_BITS-1:0] r_rem, n_rem;
    logic [CNT_BITS-1:0] r_den;
    logic [8:0]          r_quot, n_quot;
    logic [3:0]          r_cnt;
    logic                r_busy, r_done;
    logic [SUM_BITS+8:0] w_shift;
    logic [SUM_BITS+8:0] w_trial;

    // quotient always fits 8 bits since mean <= 255; bit 8 kept for safety
    always_comb begin
        w_shift = {{(SUM_BITS+9-CNT_BITS){1'b0}}, r_den} << r_cnt;
        w_trial = {9'd0, r_rem};
        n_rem   = r_rem;
        n_quot  = r_quot;
        if (w_trial >= w_shift) begin
            n_rem  = SUM_BITS'(w_trial - w_shift);
            n_quot = r_quot | (9'd1 << r_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rem  <= i_req.num;
                r_den  <= i_req.den;
                r_quot <= '0;
                r_cnt  <= 4'd8;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quot <= n_quot;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 4'd1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = (r_den == '0) ? 9'd0 : r_quot;
endmodule

>>> design/iterative_global_threshold_unit.sv
// Iterative global threshold unit. An add beat (action 0) updates the 256-bin
// histogram with a ram read, then a write. An add beat with frame_end starts
// the mean-split search: each pass scans all 256 bins through the single
// histogram ram port and runs two divisions on the shared divider, and a
// search takes up to 32 passes; then a clearing sweep empties the histogram.
// The same sweep runs after reset before the first beat is taken. A binarize
// beat (action 1) skips the histogram. Results leave through an output register.
// depends on igt_pkg, igt_ram, igt_div
module iterative_global_threshold_unit import igt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // pixel
    input  logic        s_axis_tlast,   // frame_end
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // binary_pixel, threshold_x2, converged, pass_count
    output logic        m_axis_tuser,   // is_threshold_result
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    t_state r_state, n_state;
    logic [7:0]  r_init;
    logic [4:0]  r_tol;
    logic [8:0]  r_t2, r_cur_t2, r_lo_mean;
    logic [7:0]  r_pix, r_addr;
    logic [PASS_BITS-1:0] r_passes;
    logic        r_conv;
    logic [SUM_BITS-1:0] r_lo_sum, r_hi_sum;
    logic [CNT_BITS-1:0] r_lo_cnt, r_hi_cnt;
    logic        r_ovalid, r_div_wait;
    logic [7:0]  r_obin;
    logic [8:0]  r_othr;
    logic        r_oconv, r_ouser;
    logic [5:0]  r_opass;

    logic                  w_we;
    logic [7:0]            w_addr;
    logic [COUNT_BITS-1:0] w_wdata, w_rdata;
    t_div_req              w_req;
    t_div_rsp              w_rsp;
    logic [7:0]            r_scan_bin;
    logic                  w_take;
    logic [8:0]            w_new_t2, w_diff;
    logic [CNT_BITS-1:0]   w_prod;

    igt_ram #(.WIDTH(COUNT_BITS), .DEPTH(BINS)) u_hist (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_wdata), .o_rdata(w_rdata)
    );
    igt_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovalid;
    assign o_cfg_ready   = 1'b1;
    assign w_take        = s_axis_tvalid && s_axis_tready;
    assign w_new_t2      = r_lo_mean + w_rsp.quot;
    assign w_diff        = (r_lo_mean + w_rsp.quot > r_t2) ? w_new_t2 - r_t2 : r_t2 - w_new_t2;
    assign w_prod        = w_rdata * r_scan_bin;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (w_take) n_state = s_axis_tuser ? ST_OUT : ST_INC_RD;
            ST_INC_RD:    n_state = ST_INC_WR;
            ST_INC_WR:    n_state = r_conv ? ST_SCAN : ST_IDLE;
            ST_SCAN:      if (r_addr == 8'd255) n_state = ST_SCAN_LAST;
            ST_SCAN_LAST: n_state = ST_DIV_LO;
            ST_DIV_LO:    if (w_rsp.done) n_state = ST_DIV_HI;
            ST_DIV_HI:    if (w_rsp.done) n_state = ST_CHECK;
            ST_CHECK:     n_state = (r_conv || r_div_wait) ? ST_CLEAR : ST_SCAN;
            ST_CLEAR:     if (r_addr == 8'd255) n_state = r_ouser ? ST_OUT : ST_IDLE;
            ST_OUT:       n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_addr  = r_addr;
        w_wdata = '0;
        w_req   = '0;
        unique case (r_state)
            ST_IDLE:   w_addr = s_axis_tdata;
            ST_INC_RD: w_addr = r_pix;
            ST_INC_WR: begin
                w_addr  = r_pix;
                w_we    = 1'b1;
                w_wdata = (w_rdata == BIN_MAX) ? w_rdata : w_rdata + 1'b1;
            end
            ST_SCAN_LAST: begin
                w_req.start = 1'b1;
                w_req.num   = r_lo_sum;
                w_req.den   = r_lo_cnt;
            end
            ST_DIV_LO: begin
                w_req.start = w_rsp.done;
                w_req.num   = r_hi_sum;
                w_req.den   = r_hi_cnt;
            end
            ST_CLEAR:  w_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_addr   <= '0;
            r_init   <= 8'd160;
            r_tol    <= '0;
            r_cur_t2 <= 9'd320;
            r_ovalid <= 1'b0;
            r_conv   <= 1'b0;
            r_ouser  <= 1'b0;
            r_div_wait <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_INITIAL_THRESHOLD) r_init <= i_cfg_data;
                else if (i_cfg_index == CFG_TOLERANCE_HALVES) r_tol <= i_cfg_data[4:0];
            end
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (w_take) begin
                    r_pix    <= s_axis_tdata;
                    r_conv   <= s_axis_tlast;
                    r_ouser  <= 1'b0;
                    r_t2     <= {r_init, 1'b0};
                    r_passes <= '0;
                    r_addr   <= '0;
                    r_obin   <= ({s_axis_tdata, 1'b0} < r_cur_t2) ? 8'd0 : 8'd255;
                    r_othr   <= r_cur_t2;
                    r_oconv  <= 1'b0;
                    r_opass  <= '0;
                    r_lo_sum <= '0; r_lo_cnt <= '0; r_hi_sum <= '0; r_hi_cnt <= '0;
                end
                ST_INC_WR: r_conv <= r_conv;
                ST_SCAN, ST_SCAN_LAST: begin
                    if (r_state == ST_SCAN) r_addr <= r_addr + 8'd1;
                    if (r_state == ST_SCAN && r_addr == 8'd0) begin
                        r_lo_sum <= '0; r_lo_cnt <= '0; r_hi_sum <= '0; r_hi_cnt <= '0;
                    end else if ({1'b0, r_scan_bin} * 2 < {1'b0, r_t2}) begin
                        r_lo_sum <= r_lo_sum + SUM_BITS'(w_prod);
                        r_lo_cnt <= r_lo_cnt + CNT_BITS'(w_rdata);
                    end else begin
                        r_hi_sum <= r_hi_sum + SUM_BITS'(w_prod);
                        r_hi_cnt <= r_hi_cnt + CNT_BITS'(w_rdata);
                    end
                    r_scan_bin <= r_addr;
                    if (r_state == ST_SCAN_LAST) r_addr <= '0;
                end
                ST_DIV_LO: if (w_rsp.done) r_lo_mean <= w_rsp.quot;
                ST_DIV_HI: if (w_rsp.done) begin
                    r_t2     <= w_new_t2;
                    r_passes <= r_passes + 1'b1;
                    r_conv   <= (w_diff <= {4'd0, r_tol});
                    r_div_wait <= (r_passes + 1'b1 >= PASS_BITS'(MAX_PASSES));
                end
                ST_CHECK: begin
                    r_addr <= '0;
                    r_oconv <= r_conv;
                    if (r_conv || r_div_wait) begin
                        r_cur_t2 <= r_t2;
                        r_obin   <= '0;
                        r_othr   <= r_t2;
                        r_opass  <= r_passes[5:0];
                        r_ouser  <= 1'b1;
                    end
                end
                ST_CLEAR: r_addr <= r_addr + 8'd1;
                ST_OUT: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tdata  = {r_opass, r_oconv, r_othr, r_obin};

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == ST_IDLE) else $error("ready outside idle");
    a_no_beat_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !s_axis_tready) else $error("input taken while result pending");
    a_pass_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_ouser |-> r_opass <= 6'(MAX_PASSES)) else $error("pass cap exceeded");
endmodule
